FILE: hdl/bdms_pkg.sv
// Shared types, constants and menu functions for the button debounce menu select block.
`default_nettype none

package bdms_pkg;

  localparam int MAX_BUTTONS = 4;
  localparam int BUTTONS_DEF = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd5;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 8'd10;

  // menu states
  localparam logic MENU_NORMAL = 1'b0;
  localparam logic MENU_ALT    = 1'b1;

  // buttons with special menu behaviour
  localparam logic [1:0] BTN_ALT_ON = 2'd2;  // enters alternate menu from normal menu
  localparam logic [1:0] BTN_STAY   = 2'd3;  // "none" in alternate menu keeps it

  typedef struct packed {
    logic [3:0] button_levels;
    logic       enable_level;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] button_index;
    logic       alt_menu;
    logic       last;
  } out_t;

  // presses found by one scan, with the menu state before the first of them
  typedef struct packed {
    logic [MAX_BUTTONS-1:0] mask;
    logic                   menu;
  } batch_t;

  // action code: normal menu gives 0..3, alternate menu 4..7
  function automatic logic [2:0] action_of(input logic menu, input logic [1:0] idx);
    return {menu, idx};
  endfunction

  function automatic logic next_menu(input logic menu, input logic [1:0] idx);
    logic nm;
    if (menu == MENU_NORMAL) begin
      nm = (idx == BTN_ALT_ON) ? MENU_ALT : MENU_NORMAL;
    end else begin
      nm = (idx == BTN_STAY) ? MENU_ALT : MENU_NORMAL;
    end
    return nm;
  endfunction

  // menu state after stepping through every press in index order
  function automatic logic menu_after(input logic menu, input logic [MAX_BUTTONS-1:0] mask);
    logic m;
    m = menu;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (mask[i]) begin
        m = next_menu(m, 2'(i));
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/button_debounce_menu_select.sv
// Top level: button debounce with periodic press scan and two-state menu select.
//
//   channel  direction  handshake            beat contents
//   in       input      in_valid / in_stall  in_data: button_levels, enable_level
//   out      output     out_valid/out_stall  out_data: action, button_index, alt_menu, last
//   cfg      input      cfg_we               cfg_index, cfg_data (debounce_count, check_period)
//
// On acceptance of a sample tick the debounce counters, scan timer and menu are
// updated. A scan yields 0 to 4 action beats, one per cycle from the result buffer
// while out_stall is low.
// The next tick is taken in the cycle the last beat of the previous scan leaves.
// Synchronous reset clears all debounce, menu and timer state and the result buffer.
`default_nettype none

module button_debounce_menu_select #(
  parameter int BUTTONS = bdms_pkg::BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bdms_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output bdms_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [bdms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdms_pkg::CFG_W-1:0]     cfg_data
);

  logic [bdms_pkg::CFG_W-1:0] debounce_count;
  logic [bdms_pkg::CFG_W-1:0] check_period;
  logic                       load;
  logic                       free;
  bdms_pkg::batch_t           batch;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= bdms_pkg::DEBOUNCE_RST;
      check_period   <= bdms_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdms_pkg::REG_DEBOUNCE: debounce_count <= cfg_data;
        bdms_pkg::REG_PERIOD:   check_period   <= cfg_data;
        default:                ;
      endcase
    end
  end

  assign in_stall = ~free;
  assign load     = in_valid & free;

  bdms_debounce #(
    .BUTTONS(BUTTONS)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .sample         (in_data),
    .debounce_count (debounce_count),
    .check_period   (check_period),
    .batch          (batch)
  );

  bdms_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .batch     (batch),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

endmodule

`default_nettype wire

FILE: hdl/bdms_debounce.sv
// Per-button debounce counters, scan timer and menu state update.
`default_nettype none

module bdms_debounce #(
  parameter int BUTTONS = bdms_pkg::BUTTONS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire bdms_pkg::in_t              sample,
  input  wire logic [bdms_pkg::CFG_W-1:0] debounce_count,
  input  wire logic [bdms_pkg::CFG_W-1:0] check_period,
  output bdms_pkg::batch_t                batch
);

  logic [BUTTONS-1:0] last_level, last_level_next;
  logic [BUTTONS-1:0] settling, settling_next;
  logic [BUTTONS-1:0] stable_value, stable_value_next;
  logic [BUTTONS-1:0] change_mark, change_mark_next;
  logic [7:0]         settle_count [BUTTONS];
  logic [7:0]         settle_count_next [BUTTONS];
  logic               menu_state, menu_state_next;
  logic               initialized;
  logic [7:0]         tick_count, tick_count_next;

  logic [BUTTONS-1:0] lv;
  logic [BUTTONS-1:0] marked;
  logic [BUTTONS-1:0] press;
  logic [bdms_pkg::MAX_BUTTONS-1:0] press_ext;
  logic [7:0]         tick_inc;
  logic               scan;
  logic [7:0]         settle_inc;

  always_comb begin
    last_level_next   = last_level;
    settling_next     = settling;
    stable_value_next = stable_value;
    marked            = change_mark;
    settle_inc        = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      lv[i] = sample.enable_level & sample.button_levels[i];
      settle_count_next[i] = settle_count[i];
      settle_inc = settle_count[i] + 8'd1;
      if (!initialized) begin
        last_level_next[i]   = lv[i];
        stable_value_next[i] = lv[i];
      end else if (last_level[i] != lv[i]) begin
        last_level_next[i]   = lv[i];
        settle_count_next[i] = 8'd1;
        settling_next[i]     = 1'b1;
      end else if (settling[i]) begin
        if (settle_inc >= debounce_count) begin
          settle_count_next[i] = 8'd0;
          settling_next[i]     = 1'b0;
          stable_value_next[i] = last_level[i];
          marked[i]            = 1'b1;
        end else begin
          settle_count_next[i] = settle_inc;
        end
      end
    end

    tick_inc        = tick_count + 8'd1;
    scan            = (tick_inc >= check_period);
    tick_count_next = scan ? 8'd0 : tick_inc;

    press            = scan ? (marked & stable_value_next) : '0;
    change_mark_next = marked & ~press;

    press_ext                = '0;
    press_ext[BUTTONS-1:0]   = press;
    menu_state_next          = bdms_pkg::menu_after(menu_state, press_ext);

    batch.mask = press_ext;
    batch.menu = menu_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= '0;
      settling     <= '0;
      stable_value <= '0;
      change_mark  <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        settle_count[i] <= '0;
      end
      menu_state   <= bdms_pkg::MENU_NORMAL;
      initialized  <= 1'b0;
      tick_count   <= '0;
    end else if (load) begin
      last_level   <= last_level_next;
      settling     <= settling_next;
      stable_value <= stable_value_next;
      change_mark  <= change_mark_next;
      for (int i = 0; i < BUTTONS; i++) begin
        settle_count[i] <= settle_count_next[i];
      end
      menu_state   <= menu_state_next;
      initialized  <= 1'b1;
      tick_count   <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bdms_drain.sv
// Result buffer: holds one scan's presses and hands out one action beat per press.
`default_nettype none

module bdms_drain (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bdms_pkg::batch_t batch,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output bdms_pkg::out_t        out_data,
  output logic                  free
);

  logic [bdms_pkg::MAX_BUTTONS-1:0] pend_mask, rest;
  logic                             pend_menu, menu_step;
  logic [1:0]                       idx;
  logic                             take;

  always_comb begin
    idx = '0;
    for (int i = bdms_pkg::MAX_BUTTONS - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        idx = 2'(i);
      end
    end
    rest      = pend_mask;
    rest[idx] = 1'b0;
    menu_step = bdms_pkg::next_menu(pend_menu, idx);

    out_valid             = |pend_mask;
    out_data.action       = bdms_pkg::action_of(pend_menu, idx);
    out_data.button_index = idx;
    out_data.alt_menu     = menu_step;
    out_data.last         = ~|rest;

    take = out_valid & ~out_stall;
    // a new batch may enter as the final beat of the current one leaves
    free = ~out_valid | (take & out_data.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (load) begin
      pend_mask <= batch.mask;
    end else if (take) begin
      pend_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_menu <= batch.menu;
    end else if (take) begin
      pend_menu <= menu_step;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_button_debounce_menu_select.sv
// Testbench for button_debounce_menu_select: tick stimulus, debounce/scan predictor, checks.
`timescale 1ns / 100ps

module tb_button_debounce_menu_select;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_WAIT = 8;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  bdms_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bdms_pkg::out_t                 out_data;
  logic                           cfg_we = 1'b0;
  logic [bdms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bdms_pkg::CFG_W-1:0]     cfg_data = '0;

  button_debounce_menu_select DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ticks waiting to be driven, actions waiting to come out
  bdms_pkg::in_t  sample_ticks [$];
  bdms_pkg::out_t expected_actions [$];
  int             errors = 0;
  int             cycles = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  logic           start_hold = 1'b0;
  logic           hold_taken;
  int             hold_left;
  bdms_pkg::out_t got;
  bdms_pkg::out_t want;

  // predictor state and register copies
  logic [bdms_pkg::CFG_W-1:0] settle_limit = bdms_pkg::DEBOUNCE_RST;
  logic [bdms_pkg::CFG_W-1:0] scan_period  = bdms_pkg::PERIOD_RST;
  logic [3:0]       prev_level = '0;
  logic [3:0]       settling = '0;
  logic [3:0]       stable_level = '0;
  logic [3:0]       press_mark = '0;
  logic [7:0]       settle_cnt [4] = '{default: '0};
  logic             menu = bdms_pkg::MENU_NORMAL;
  logic             primed = 1'b0;
  logic [7:0]       tick_cnt = '0;

  // directed ticks {levels, enable}: walks every action in both menus
  logic [4:0] directed_ticks [25] = '{
    {4'hF, 1'b0}, {4'h1, 1'b1}, {4'h1, 1'b1}, {4'h4, 1'b1}, {4'h4, 1'b1},
    {4'hC, 1'b1}, {4'hC, 1'b1}, {4'hD, 1'b1}, {4'hD, 1'b1}, {4'hF, 1'b1},
    {4'hF, 1'b1}, {4'hB, 1'b1}, {4'hB, 1'b1}, {4'hF, 1'b1}, {4'hF, 1'b1},
    {4'hF, 1'b0}, {4'h0, 1'b1}, {4'h6, 1'b1}, {4'h6, 1'b1}, {4'h2, 1'b1},
    {4'h2, 1'b1}, {4'h6, 1'b1}, {4'h6, 1'b1}, {4'hE, 1'b1}, {4'hE, 1'b1}
  };

  task automatic debounce_and_scan(input bdms_pkg::in_t beat);
    logic [3:0]     lv;
    logic [3:0]     hits;
    bdms_pkg::out_t act;
    lv = beat.enable_level ? beat.button_levels : 4'b0000;
    for (int i = 0; i < 4; i++) begin
      if (!primed) begin
        prev_level[i] = lv[i];
        stable_level[i] = lv[i];
      end else if (prev_level[i] != lv[i]) begin
        prev_level[i] = lv[i];
        settle_cnt[i] = 8'd1;
        settling[i] = 1'b1;
      end else if (settling[i]) begin
        settle_cnt[i] = settle_cnt[i] + 8'd1;
        if (settle_cnt[i] >= settle_limit) begin
          settle_cnt[i] = '0;
          settling[i] = 1'b0;
          stable_level[i] = prev_level[i];
          press_mark[i] = 1'b1;
        end
      end
    end
    primed = 1'b1;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= scan_period) begin
      tick_cnt = '0;
      // released marks stay set; only presses are consumed
      hits = press_mark & stable_level;
      for (int i = 0; i < 4; i++) begin
        if (hits[i]) begin
          press_mark[i] = 1'b0;
          act.action = {menu, 2'(i)};
          if (menu == bdms_pkg::MENU_NORMAL) begin
            menu = (2'(i) == bdms_pkg::BTN_ALT_ON) ? bdms_pkg::MENU_ALT : bdms_pkg::MENU_NORMAL;
          end else begin
            menu = (2'(i) == bdms_pkg::BTN_STAY) ? bdms_pkg::MENU_ALT : bdms_pkg::MENU_NORMAL;
          end
          act.button_index = 2'(i);
          act.alt_menu = menu;
          act.last = ((hits >> (i + 1)) == 4'b0000);
          expected_actions.push_back(act);
        end
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        debounce_and_scan(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (sample_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= sample_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
    end else if (start_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // action checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = out_data;
      if (expected_actions.size() == 0) begin
        $error("unexpected action beat: action %0d button %0d", got.action, got.button_index);
        errors++;
      end else begin
        want = expected_actions.pop_front();
        if (got.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, got.action);
          errors++;
        end
        if (got.button_index !== want.button_index) begin
          $error("button_index: expected %0d, got %0d", want.button_index, got.button_index);
          errors++;
        end
        if (got.alt_menu !== want.alt_menu) begin
          $error("alt_menu: expected %0d, got %0d", want.alt_menu, got.alt_menu);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_button_debounce_menu_select: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [bdms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdms_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bdms_pkg::REG_DEBOUNCE) begin
      settle_limit = val;
    end else begin
      scan_period = val;
    end
  endtask

  // wait for every tick to go in and every action to come out, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (sample_ticks.size() != 0 || in_valid || expected_actions.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // runs of held levels long enough to settle, with the odd one-sample glitch
  task automatic queue_runs(input int n);
    bdms_pkg::in_t b;
    int            run;
    int            hold;
    int            queued;
    queued = 0;
    hold = (settle_limit == 0) ? 2 : settle_limit + 1;
    while (queued < n) begin
      b.button_levels = 4'($urandom_range(15));
      b.enable_level = ($urandom_range(99) < 85);
      run = ($urandom_range(9) == 0) ? 1 : hold + $urandom_range(3);
      repeat (run) begin
        sample_ticks.push_back(b);
        queued++;
      end
    end
  endtask

  task automatic run_phase(input logic [bdms_pkg::CFG_W-1:0] dbn,
                           input logic [bdms_pkg::CFG_W-1:0] per,
                           input int idle, input int stall, input int n);
    write_reg(bdms_pkg::REG_DEBOUNCE, dbn);
    write_reg(bdms_pkg::REG_PERIOD, per);
    send_idle_pct = idle;
    stall_pct = stall;
    queue_runs(n);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed walk, settle after one extra sample and scan every tick
    write_reg(bdms_pkg::REG_DEBOUNCE, 8'd1);
    write_reg(bdms_pkg::REG_PERIOD, 8'd1);
    for (int k = 0; k < 25; k++) begin
      sample_ticks.push_back(bdms_pkg::in_t'(directed_ticks[k]));
    end
    drain();

    run_phase(bdms_pkg::DEBOUNCE_RST, bdms_pkg::PERIOD_RST, 0, 0, 16);
    run_phase(8'd2, 8'd3, 69, 0, 16);
    run_phase(8'd1, 8'd1, 0, 69, 16);
    run_phase(8'd3, 8'd2, 36, 36, 16);

    // zero settings act as one; receiver holds off so the block backs up
    write_reg(bdms_pkg::REG_DEBOUNCE, 8'd0);
    write_reg(bdms_pkg::REG_PERIOD, 8'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    queue_runs(15);
    @(posedge clk);
    start_hold <= 1'b1;
    drain();
    queue_runs(10);
    drain();

    // longest settle and scan interval: nothing settles, the tick count runs on
    write_reg(bdms_pkg::REG_DEBOUNCE, 8'd255);
    write_reg(bdms_pkg::REG_PERIOD, 8'd255);
    repeat (4) sample_ticks.push_back(bdms_pkg::in_t'({4'h0, 1'b1}));
    repeat (6) sample_ticks.push_back(bdms_pkg::in_t'({4'hF, 1'b1}));
    drain();

    // period drops below the running tick count: the next tick scans
    run_phase(8'd1, 8'd1, 36, 36, 15);

    if (errors == 0) begin
      $display("tb_button_debounce_menu_select: done, clean");
    end else begin
      $display("tb_button_debounce_menu_select: done, errors");
    end
    $finish;
  end

endmodule
